>>> sv/srs_pkg.sv
// Shared types and constants for the sorted range search unit.
`timescale 1ns / 1ps
`default_nettype none

package srs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int VALUE_BITS  = 32;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = IDX_BITS + 1;
    // Signed search bounds: lo reaches the depth, hi reaches minus one
    localparam int BOUND_BITS  = IDX_BITS + 2;

    // Command codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef logic signed [VALUE_BITS-1:0] srs_value_t;
    typedef logic [IDX_BITS-1:0]          srs_addr_t;

    // Command transfer
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } srs_cmd_t;

    // Result transfer
    typedef struct packed {
        logic [1:0] status;
        logic [9:0] first_index;
        logic [9:0] last_index;
    } srs_result_t;

    // Table write port
    typedef struct packed {
        logic       en;
        srs_addr_t  addr;
        srs_value_t data;
    } srs_wr_t;

    // Table read port
    typedef struct packed {
        logic      en;
        srs_addr_t addr;
    } srs_rd_t;

endpackage

`default_nettype wire

>>> sv/srs_table.sv
// Element table: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module srs_table (
    input  wire logic            clk,
    input  wire srs_pkg::srs_wr_t wr,
    input  wire srs_pkg::srs_rd_t rd,
    output srs_pkg::srs_value_t  rd_data
);

    srs_pkg::srs_value_t mem [srs_pkg::TABLE_DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/sorted_range_search_unit.sv
// Sorted range search unit: sorted table with lower/upper bound binary search.
//
// Usage:
//   A command (cmd.op, cmd.value) transfers on a rising edge with start high
//   and busy low. Every command yields exactly one result on result, marked
//   by done for one cycle; the receiver cannot stall and must take it then.
//   Append writes the value at the end of the table (status full and dropped
//   once the table holds TABLE_DEPTH entries). Clear empties the table. Query
//   returns the first and last index of the run equal to the value, or
//   status not found. Appends are expected in ascending order.
// Latency and throughput:
//   Append, clear and unused codes: result in the cycle after the transfer,
//   and busy stays low, so a command may be given every cycle.
//   Query: two binary searches share one table read port and one comparator.
//   Each probe reads the table (state ST_PROBE), then compares and updates
//   the bounds (ST_COMPARE); each search closes in ST_PROBE once the bounds
//   cross. busy is high meanwhile.
// Reset:
//   rst_n clears the entry count and the sequencer; table contents are not
//   cleared and are only read below the entry count.
`timescale 1ns / 1ps
`default_nettype none

module sorted_range_search_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire srs_pkg::srs_cmd_t cmd,
    output logic                   done,
    output srs_pkg::srs_result_t   result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE
    } state_t;

    typedef logic signed [srs_pkg::BOUND_BITS-1:0] bound_t;

    state_t                     state_reg,  state_next;
    bound_t                     lo_reg,     lo_next;
    bound_t                     hi_reg,     hi_next;
    logic                       hit_reg,    hit_next;
    logic                       upper_reg,  upper_next;
    logic [srs_pkg::IDX_BITS-1:0] first_reg, first_next;
    logic [srs_pkg::CNT_BITS-1:0] count_reg, count_next;
    srs_pkg::srs_value_t        key_reg,    key_next;
    logic                       done_reg,   done_next;
    srs_pkg::srs_result_t       result_reg, result_next;

    srs_pkg::srs_wr_t           wr;
    srs_pkg::srs_rd_t           rd;
    srs_pkg::srs_value_t        rd_data;

    logic                       accept;
    logic signed [srs_pkg::BOUND_BITS:0] mid_sum;
    srs_pkg::srs_addr_t         mid;
    logic                       go_left;
    bound_t                     hi_init;
    bound_t                     last_bound;

    srs_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign accept = start && !busy;

    // Shared datapath: midpoint, comparator, bound arithmetic
    assign mid_sum    = {lo_reg[srs_pkg::BOUND_BITS-1], lo_reg}
                      + {hi_reg[srs_pkg::BOUND_BITS-1], hi_reg};
    assign mid        = mid_sum[srs_pkg::IDX_BITS:1];
    assign go_left    = upper_reg ? (rd_data > key_reg) : (rd_data >= key_reg);
    assign hi_init    = $signed({1'b0, count_reg}) - bound_t'(1);
    assign last_bound = lo_reg - bound_t'(1);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        hit_next    = hit_reg;
        upper_next  = upper_reg;
        first_next  = first_reg;
        count_next  = count_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        wr.en       = 1'b0;
        wr.addr     = count_reg[srs_pkg::IDX_BITS-1:0];
        wr.data     = cmd.value[srs_pkg::VALUE_BITS-1:0];
        rd.en       = 1'b0;
        rd.addr     = mid;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    result_next.status      = srs_pkg::STATUS_OK;
                    result_next.first_index = '0;
                    result_next.last_index  = '0;
                    unique case (cmd.op)
                        srs_pkg::OP_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg >= srs_pkg::CNT_BITS'(srs_pkg::TABLE_DEPTH))
                            begin
                                result_next.status = srs_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr.en      = 1'b1;
                                count_next = count_reg + srs_pkg::CNT_BITS'(1);
                            end
                        end
                        srs_pkg::OP_QUERY:
                        begin
                            key_next   = cmd.value[srs_pkg::VALUE_BITS-1:0];
                            lo_next    = '0;
                            hi_next    = hi_init;
                            hit_next   = 1'b0;
                            upper_next = 1'b0;
                            state_next = ST_PROBE;
                        end
                        srs_pkg::OP_CLEAR:
                        begin
                            done_next  = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_PROBE:
            begin
                if (lo_reg <= hi_reg)
                begin
                    rd.en      = 1'b1;
                    state_next = ST_COMPARE;
                end
                else if (!upper_reg)
                begin
                    // Lower bound done: found only if its entry matched
                    if (!hit_reg)
                    begin
                        result_next.status = srs_pkg::STATUS_NOT_FOUND;
                        done_next          = 1'b1;
                        state_next         = ST_IDLE;
                    end
                    else
                    begin
                        first_next = lo_reg[srs_pkg::IDX_BITS-1:0];
                        lo_next    = '0;
                        hi_next    = hi_init;
                        upper_next = 1'b1;
                    end
                end
                else
                begin
                    result_next.status      = srs_pkg::STATUS_OK;
                    result_next.first_index = first_reg;
                    result_next.last_index  = last_bound[srs_pkg::IDX_BITS-1:0];
                    done_next               = 1'b1;
                    state_next              = ST_IDLE;
                end
            end

            ST_COMPARE:
            begin
                // Last left move of the lower search sits on the lower bound
                if (go_left)
                begin
                    hi_next  = bound_t'({1'b0, mid}) - bound_t'(1);
                    hit_next = (rd_data == key_reg);
                end
                else
                begin
                    lo_next = bound_t'({1'b0, mid}) + bound_t'(1);
                end
                state_next = ST_PROBE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            upper_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            upper_reg <= upper_next;
            hit_reg   <= hit_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        first_reg  <= first_next;
        key_reg    <= key_next;
        result_reg <= result_next;
    end

`ifndef NO_ASSERTIONS
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a search is running");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= srs_pkg::CNT_BITS'(srs_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op != srs_pkg::OP_QUERY) |=> (done && !busy))
        else $error("non-query command did not complete in one cycle");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op == srs_pkg::OP_QUERY) |=> (busy && !done))
        else $error("query did not start a search");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == srs_pkg::STATUS_NOT_FOUND)
            |-> (result.first_index == '0 && result.last_index == '0))
        else $error("not-found result carries indices");
`endif

endmodule

`default_nettype wire
